### hdl/apst_pkg.sv
// ----------------------------------------------------------------------------
// Access point session table package
// Table geometry, entry layout, action codes and the scan unit's interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apst_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam logic [21:0] STALE_AGE_RST = 22'd60000;
    localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;
    localparam logic signed [7:0] SIG_MAX = 8'sd127;

    typedef enum logic [2:0] {
        ACT_MERGED   = 3'd0,
        ACT_INSERTED = 3'd1,
        ACT_STALE    = 3'd2,
        ACT_WEAKEST  = 3'd3,
        ACT_DROPPED  = 3'd4
    } t_action;

    typedef struct packed {
        logic [47:0]       key;
        logic [31:0]       packets;
        logic [31:0]       tx_octets;
        logic [31:0]       rx_octets;
        logic [31:0]       byte_sum;
        logic [63:0]       square_sum;
        logic [31:0]       seen;
        logic signed [7:0] sig_latest;
        logic signed [7:0] sig_low;
        logic signed [7:0] sig_high;
    } t_entry;

    typedef struct packed {
        logic              clear;
        logic              sample;
        logic [SLOT_W-1:0] idx;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic [31:0]       old_seen;
        logic [SLOT_W-1:0] oldest_idx;
        logic signed [7:0] weakest_sig;
        logic [SLOT_W-1:0] weak_slot;
    } t_scan_res;

endpackage

### hdl/apst_scan.sv
// ----------------------------------------------------------------------------
// Access point session table scan unit
// Compares each entry read from the table against the record key and keeps
// running trackers of the oldest and the weakest entry seen so far.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apst_scan
    import apst_pkg::*;
(
    input  logic        i_clk,
    input  t_scan_ctl   i_ctl,
    input  t_entry      i_entry,
    input  logic [47:0] i_key,
    output t_scan_res   o_res
);

    logic [31:0]       r_old_time;
    logic [SLOT_W-1:0] r_old_idx;
    logic signed [7:0] r_weak_sig;
    logic [SLOT_W-1:0] r_weak_idx;

    // Strict comparisons keep the lowest slot on ties.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_old_time <= TIME_MAX;
            r_old_idx  <= '0;
            r_weak_sig <= SIG_MAX;
            r_weak_idx <= '0;
        end else if (i_ctl.sample) begin
            if (i_entry.seen < r_old_time) begin
                r_old_time <= i_entry.seen;
                r_old_idx  <= i_ctl.idx;
            end
            if ($signed(i_entry.sig_latest) < $signed(r_weak_sig)) begin
                r_weak_sig <= i_entry.sig_latest;
                r_weak_idx <= i_ctl.idx;
            end
        end
    end

    always_comb begin
        o_res.hit         = i_ctl.sample && (i_entry.key == i_key);
        o_res.old_seen    = r_old_time;
        o_res.oldest_idx  = r_old_idx;
        o_res.weakest_sig = r_weak_sig;
        o_res.weak_slot   = r_weak_idx;
    end

endmodule

### hdl/ap_session_table_merge.sv
// ----------------------------------------------------------------------------
// Access point session table merge
// A hit is merged, a miss takes the next free slot, and a full table replaces
// the stale oldest or the weakest entry, or drops the record. Records are taken
// one at a time: the next is accepted once the result word is registered; the
// slot walk and six-pass shared 32-bit adder pace each one.
// Reset (synchronous, active low) empties the count, sets the stale age to
// 60000 and drops any pending result; table contents need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ap_session_table_merge
    import apst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [21:0]       i_cfg_data,
    // record input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [47:0]       i_bssid,
    input  logic [31:0]       i_packet_count,
    input  logic [31:0]       i_tx_byte_count,
    input  logic [31:0]       i_rx_byte_count,
    input  logic [31:0]       i_byte_sum,
    input  logic [63:0]       i_byte_square_sum,
    input  logic [31:0]       i_seen_time_ms,
    input  logic signed [7:0] i_signal_dbm,
    input  logic signed [7:0] i_signal_low_dbm,
    input  logic signed [7:0] i_signal_high_dbm,
    input  logic [31:0]       i_now_ms,
    input  logic              i_last_in_batch,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_action,
    output logic [4:0]        o_slot,
    output logic [5:0]        o_entry_count,
    output logic              o_batch_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_MISS,
        S_EVICT,
        S_MERGE,
        S_WRITE,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_PKT,
        M_TX,
        M_RX,
        M_SUM,
        M_SQ_LO,
        M_SQ_HI
    } t_mstep;

    t_state            r_state;
    t_mstep            r_step;
    logic [21:0]       r_stale;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_idx;
    logic              r_issued;
    logic              r_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx;
    logic              r_cmp_last;
    logic [SLOT_W-1:0] r_slot;
    t_action           r_action;
    logic              r_carry;
    logic              r_out_valid;
    logic [2:0]        r_out_action;
    logic [4:0]        r_out_slot;
    logic [5:0]        r_out_count;
    logic              r_out_batch;

    t_entry            r_rec;
    logic [31:0]       r_now;
    logic              r_batch;
    t_entry            r_ent;

    t_entry            r_mem [TABLE_SLOTS];
    t_entry            r_rd_data;

    logic              in_accept;
    logic              issue_last;
    logic              mem_we;
    logic [31:0]       add_a;
    logic [31:0]       add_b;
    logic              add_cin;
    logic [32:0]       add_res;
    logic signed [7:0] n_low;
    logic signed [7:0] n_high;
    t_scan_ctl         scan_ctl;
    t_scan_res         scan_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign issue_last  = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign mem_we      = (r_state == S_WRITE);

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out_action;
    assign o_slot        = r_out_slot;
    assign o_entry_count = r_out_count;
    assign o_batch_done  = r_out_batch;

    // Table storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= r_ent;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_comb begin
        scan_ctl.clear  = in_accept;
        scan_ctl.sample = (r_state == S_SRCH) && r_cmp_vld;
        scan_ctl.idx    = r_cmp_idx;
    end

    apst_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_entry (r_rd_data),
        .i_key   (r_rec.key),
        .o_res   (scan_res)
    );

    // Shared 32-bit adder: counter merge passes, and the age subtraction.
    always_comb begin
        add_a   = r_ent.packets;
        add_b   = r_rec.packets;
        add_cin = 1'b0;
        if (r_state == S_EVICT) begin
            add_a   = r_now;
            add_b   = ~scan_res.old_seen;
            add_cin = 1'b1;
        end else begin
            case (r_step)
                M_TX: begin
                    add_a = r_ent.tx_octets;
                    add_b = r_rec.tx_octets;
                end
                M_RX: begin
                    add_a = r_ent.rx_octets;
                    add_b = r_rec.rx_octets;
                end
                M_SUM: begin
                    add_a = r_ent.byte_sum;
                    add_b = r_rec.byte_sum;
                end
                M_SQ_LO: begin
                    add_a = r_ent.square_sum[31:0];
                    add_b = r_rec.square_sum[31:0];
                end
                M_SQ_HI: begin
                    add_a   = r_ent.square_sum[63:32];
                    add_b   = r_rec.square_sum[63:32];
                    add_cin = r_carry;
                end
                default: begin
                    add_a = r_ent.packets;
                    add_b = r_rec.packets;
                end
            endcase
        end
        add_res = {1'b0, add_a} + {1'b0, add_b} + 33'(add_cin);
    end

    // A stored 0 in low or high means unset and always takes the record's value.
    always_comb begin
        n_low  = r_ent.sig_low;
        n_high = r_ent.sig_high;
        if ($signed(r_rec.sig_low) < $signed(r_ent.sig_low) || r_ent.sig_low == 8'sd0) begin
            n_low = r_rec.sig_low;
        end
        if ($signed(r_rec.sig_high) > $signed(r_ent.sig_high) || r_ent.sig_high == 8'sd0) begin
            n_high = r_rec.sig_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= M_PKT;
            r_stale     <= STALE_AGE_RST;
            r_count     <= '0;
            r_idx       <= '0;
            r_issued    <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_stale <= i_cfg_data;
            end
            // In S_OUT the valid flag is handled together with the new word.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_rec.key        <= i_bssid;
                        r_rec.packets    <= i_packet_count;
                        r_rec.tx_octets  <= i_tx_byte_count;
                        r_rec.rx_octets  <= i_rx_byte_count;
                        r_rec.byte_sum   <= i_byte_sum;
                        r_rec.square_sum <= i_byte_square_sum;
                        r_rec.seen       <= i_seen_time_ms;
                        r_rec.sig_latest <= i_signal_dbm;
                        r_rec.sig_low    <= i_signal_low_dbm;
                        r_rec.sig_high   <= i_signal_high_dbm;
                        r_now            <= i_now_ms;
                        r_batch          <= i_last_in_batch;
                        r_idx            <= '0;
                        r_issued         <= 1'b0;
                        r_cmp_vld        <= 1'b0;
                        r_state          <= (r_count == '0) ? S_MISS : S_SRCH;
                    end
                end

                // One slot read issued per cycle; its compare follows in the next cycle.
                S_SRCH: begin
                    if (!r_issued) begin
                        r_cmp_vld  <= 1'b1;
                        r_cmp_idx  <= r_idx;
                        r_cmp_last <= issue_last;
                        if (issue_last) begin
                            r_issued <= 1'b1;
                        end else begin
                            r_idx <= r_idx + SLOT_W'(1);
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld && scan_res.hit) begin
                        r_slot   <= r_cmp_idx;
                        r_ent    <= r_rd_data;
                        r_action <= ACT_MERGED;
                        r_step   <= M_PKT;
                        r_state  <= S_MERGE;
                    end else if (r_cmp_vld && r_cmp_last) begin
                        r_state <= S_MISS;
                    end
                end

                S_MISS: begin
                    if (r_count < CNT_W'(TABLE_SLOTS)) begin
                        r_slot   <= SLOT_W'(r_count);
                        r_count  <= r_count + CNT_W'(1);
                        r_ent    <= r_rec;
                        r_action <= ACT_INSERTED;
                        r_state  <= S_WRITE;
                    end else begin
                        r_state <= S_EVICT;
                    end
                end

                S_EVICT: begin
                    r_ent <= r_rec;
                    if (add_res[31:0] > 32'(r_stale)) begin
                        r_slot   <= scan_res.oldest_idx;
                        r_action <= ACT_STALE;
                        r_state  <= S_WRITE;
                    end else if ($signed(r_rec.sig_latest) > $signed(scan_res.weakest_sig)) begin
                        r_slot   <= scan_res.weak_slot;
                        r_action <= ACT_WEAKEST;
                        r_state  <= S_WRITE;
                    end else begin
                        r_slot   <= '0;
                        r_action <= ACT_DROPPED;
                        r_state  <= S_OUT;
                    end
                end

                S_MERGE: begin
                    r_carry <= add_res[32];
                    unique case (r_step)
                        M_PKT: begin
                            r_ent.packets    <= add_res[31:0];
                            r_ent.seen       <= r_rec.seen;
                            r_ent.sig_latest <= r_rec.sig_latest;
                            r_ent.sig_low    <= n_low;
                            r_ent.sig_high   <= n_high;
                            r_step           <= M_TX;
                        end
                        M_TX: begin
                            r_ent.tx_octets <= add_res[31:0];
                            r_step          <= M_RX;
                        end
                        M_RX: begin
                            r_ent.rx_octets <= add_res[31:0];
                            r_step          <= M_SUM;
                        end
                        M_SUM: begin
                            r_ent.byte_sum <= add_res[31:0];
                            r_step         <= M_SQ_LO;
                        end
                        M_SQ_LO: begin
                            r_ent.square_sum[31:0] <= add_res[31:0];
                            r_step                 <= M_SQ_HI;
                        end
                        M_SQ_HI: begin
                            r_ent.square_sum[63:32] <= add_res[31:0];
                            r_step                  <= M_PKT;
                            r_state                 <= S_WRITE;
                        end
                        default: begin
                            r_step <= M_PKT;
                        end
                    endcase
                end

                S_WRITE: begin
                    r_state <= S_OUT;
                end

                // Waits only if an earlier word is still held by the consumer.
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_action <= r_action;
                        r_out_slot   <= 5'(r_slot);
                        r_out_count  <= 6'(r_count);
                        r_out_batch  <= r_batch;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SLOTS))
        else $error("entry count beyond table size");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && r_cmp_vld) |-> (CNT_W'(r_cmp_idx) < r_count))
        else $error("search compared a slot that was never filled");

    a_count_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> ($past(r_state) == S_MISS))
        else $error("entry count changed outside an insert");

    a_drop_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_action == ACT_DROPPED) |-> (r_out_slot == 5'd0))
        else $error("dropped record reports a non-zero slot");

endmodule

### tb/tb_ap_session_table_merge.sv
// ----------------------------------------------------------------------------
// Access point session table merge testbench
// Pushes per-interval records through the merge block, with random idling on
// the record and result channels. A software copy of the session table
// predicts the action, slot, entry count and batch mark of each result word,
// and every field of every result word is checked in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ap_session_table_merge;
    import apst_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 48;

    typedef struct {
        t_entry      e;
        logic [31:0] now;
        logic        last;
    } t_record;

    typedef struct {
        t_action    action;
        logic [4:0] slot;
        logic [5:0] count;
        logic       batch;
    } t_outcome;

    // Session table copy and the queue of outcomes still to arrive.
    class session_scoreboard;
        t_entry      entries[TABLE_SLOTS];
        int          used;
        logic [21:0] stale_age;
        t_outcome    awaited[$];
        int          errors;

        function new();
            used      = 0;
            stale_age = STALE_AGE_RST;
            errors    = 0;
        endfunction

        function void merge_into(int s, t_entry r);
            logic signed [7:0] lo, hi, in_lo, in_hi;
            lo    = entries[s].sig_low;
            hi    = entries[s].sig_high;
            in_lo = r.sig_low;
            in_hi = r.sig_high;
            entries[s].packets    = entries[s].packets + r.packets;
            entries[s].tx_octets  = entries[s].tx_octets + r.tx_octets;
            entries[s].rx_octets  = entries[s].rx_octets + r.rx_octets;
            entries[s].byte_sum   = entries[s].byte_sum + r.byte_sum;
            entries[s].square_sum = entries[s].square_sum + r.square_sum;
            entries[s].seen       = r.seen;
            entries[s].sig_latest = r.sig_latest;
            // A stored zero means the bound was never set, so it always yields.
            if (in_lo < lo || lo == 0) lo = in_lo;
            if (in_hi > hi || hi == 0) hi = in_hi;
            entries[s].sig_low  = lo;
            entries[s].sig_high = hi;
        endfunction

        function void note_record(t_record r);
            t_outcome          o;
            logic [31:0]       oldest_t;
            logic signed [7:0] lowest, sig, in_sig;
            int                oldest_i, weakest_i, i;
            bit                found;
            found    = 1'b0;
            o.action = ACT_DROPPED;
            o.slot   = '0;
            for (i = 0; i < used; i++) begin
                if (!found && entries[i].key == r.e.key) begin
                    merge_into(i, r.e);
                    o.action = ACT_MERGED;
                    o.slot   = 5'(i);
                    found    = 1'b1;
                end
            end
            if (!found && used < TABLE_SLOTS) begin
                entries[used] = r.e;
                o.action      = ACT_INSERTED;
                o.slot        = 5'(used);
                used++;
            end else if (!found) begin
                oldest_t  = TIME_MAX;
                lowest    = SIG_MAX;
                oldest_i  = 0;
                weakest_i = 0;
                // Strict comparisons keep the lowest slot on a tie.
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    sig = entries[i].sig_latest;
                    if (entries[i].seen < oldest_t) begin
                        oldest_t = entries[i].seen;
                        oldest_i = i;
                    end
                    if (sig < lowest) begin
                        lowest    = sig;
                        weakest_i = i;
                    end
                end
                in_sig = r.e.sig_latest;
                // The age wraps modulo 2^32 along with the millisecond clock.
                if (r.now - oldest_t > {10'd0, stale_age}) begin
                    entries[oldest_i] = r.e;
                    o.action          = ACT_STALE;
                    o.slot            = 5'(oldest_i);
                end else if (in_sig > lowest) begin
                    entries[weakest_i] = r.e;
                    o.action           = ACT_WEAKEST;
                    o.slot             = 5'(weakest_i);
                end
            end
            o.count = 6'(used);
            o.batch = r.last;
            awaited.push_back(o);
        endfunction

        function void check(logic [2:0] act, logic [4:0] slot, logic [5:0] cnt,
                            logic batch);
            t_outcome o;
            if (awaited.size() == 0) begin
                $display("%0t: result word with none expected: action %0d slot %0d",
                         $time, act, slot);
                errors++;
            end else begin
                o = awaited.pop_front();
                if (act !== o.action) begin
                    $display("%0t: action expected %0d actual %0d", $time, o.action, act);
                    errors++;
                end
                if (slot !== o.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, o.slot, slot);
                    errors++;
                end
                if (cnt !== o.count) begin
                    $display("%0t: entry count expected %0d actual %0d", $time, o.count, cnt);
                    errors++;
                end
                if (batch !== o.batch) begin
                    $display("%0t: batch mark expected %0b actual %0b", $time, o.batch, batch);
                    errors++;
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [21:0]       i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [47:0]       i_bssid;
    logic [31:0]       i_packet_count;
    logic [31:0]       i_tx_byte_count;
    logic [31:0]       i_rx_byte_count;
    logic [31:0]       i_byte_sum;
    logic [63:0]       i_byte_square_sum;
    logic [31:0]       i_seen_time_ms;
    logic signed [7:0] i_signal_dbm;
    logic signed [7:0] i_signal_low_dbm;
    logic signed [7:0] i_signal_high_dbm;
    logic [31:0]       i_now_ms;
    logic              i_last_in_batch;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [2:0]        o_action;
    logic [4:0]        o_slot;
    logic [5:0]        o_entry_count;
    logic              o_batch_done;

    session_scoreboard sb;
    int                send_idle_pct = 6;
    int                recv_idle_pct = 75;
    int                cycle_count   = 0;
    logic [31:0]       clock_ms;

    ap_session_table_merge DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_bssid           (i_bssid),
        .i_packet_count    (i_packet_count),
        .i_tx_byte_count   (i_tx_byte_count),
        .i_rx_byte_count   (i_rx_byte_count),
        .i_byte_sum        (i_byte_sum),
        .i_byte_square_sum (i_byte_square_sum),
        .i_seen_time_ms    (i_seen_time_ms),
        .i_signal_dbm      (i_signal_dbm),
        .i_signal_low_dbm  (i_signal_low_dbm),
        .i_signal_high_dbm (i_signal_high_dbm),
        .i_now_ms          (i_now_ms),
        .i_last_in_batch   (i_last_in_batch),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_action          (o_action),
        .o_slot            (o_slot),
        .o_entry_count     (o_entry_count),
        .o_batch_done      (o_batch_done)
    );

    always #4 i_clk = ~i_clk;

    // Result side: check each accepted word, then decide the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check(o_action, o_slot, o_entry_count, o_batch_done);
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return '1;
        else if (pick < 14) return '0;
        else return $urandom();
    endfunction

    function automatic logic signed [7:0] rand_level();
        if ($urandom_range(99) < 25) return 8'sd0;
        return 8'($urandom_range(255));
    endfunction

    function automatic t_record fixed_record(input logic [47:0] key,
            input logic [31:0] fill, input logic [63:0] square,
            input logic [31:0] seen, input logic [7:0] sig, input logic [7:0] low,
            input logic [7:0] high, input logic [31:0] now, input logic last);
        t_record r;
        r.e.key        = key;
        r.e.packets    = fill;
        r.e.tx_octets  = ~fill;
        r.e.rx_octets  = fill;
        r.e.byte_sum   = ~fill;
        r.e.square_sum = square;
        r.e.seen       = seen;
        r.e.sig_latest = sig;
        r.e.sig_low    = low;
        r.e.sig_high   = high;
        r.now          = now;
        r.last         = last;
        return r;
    endfunction

    // About 55 percent of records revisit a stored key; the rest are new access points.
    // A loud run pushes the latest signal to the top of the scale so that
    // the whole table ends up at the ceiling and new records start to drop.
    function automatic t_record make_record(bit loud);
        t_record     r;
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        if (sb.used != 0 && $urandom_range(99) < 55)
            r.e.key = sb.entries[$urandom_range(sb.used - 1)].key;
        else
            r.e.key = wide[47:0];
        r.e.packets    = rand_word();
        r.e.tx_octets  = rand_word();
        r.e.rx_octets  = rand_word();
        r.e.byte_sum   = rand_word();
        r.e.square_sum = ($urandom_range(9) == 0) ? '1 : {$urandom(), $urandom()};
        if (loud && $urandom_range(99) < 85)
            r.e.sig_latest = SIG_MAX;
        else
            r.e.sig_latest = 8'($urandom_range(255));
        r.e.sig_low  = rand_level();
        r.e.sig_high = rand_level();
        // Time often stands still so that equal seen times occur.
        if ($urandom_range(99) >= 20)
            clock_ms = clock_ms + 32'($urandom_range(5000, 1));
        if (!loud && $urandom_range(99) < 8) begin
            r.now    = rand_word();
            r.e.seen = rand_word();
        end else begin
            r.now    = clock_ms;
            r.e.seen = ($urandom_range(99) < 30) ? clock_ms
                                                 : clock_ms - 32'($urandom_range(2000));
        end
        r.last = ($urandom_range(9) == 0);
        return r;
    endfunction

    task automatic push_record(input t_record r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_bssid           <= r.e.key;
        i_packet_count    <= r.e.packets;
        i_tx_byte_count   <= r.e.tx_octets;
        i_rx_byte_count   <= r.e.rx_octets;
        i_byte_sum        <= r.e.byte_sum;
        i_byte_square_sum <= r.e.square_sum;
        i_seen_time_ms    <= r.e.seen;
        i_signal_dbm      <= r.e.sig_latest;
        i_signal_low_dbm  <= r.e.sig_low;
        i_signal_high_dbm <= r.e.sig_high;
        i_now_ms          <= r.now;
        i_last_in_batch   <= r.last;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_record(r);
    endtask

    // Holds the record channel quiet until every awaited word has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic write_stale_age(input logic [21:0] age);
        wait_drained();
        i_cfg_data  <= age;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        sb.stale_age = age;
    endtask

    task automatic run_segment(input logic [21:0] age, input int send_pct,
                               input int recv_pct, input bit loud, input int words);
        write_stale_age(age);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (words) begin
            if ($urandom_range(199) == 0) wait_drained();
            push_record(make_record(loud));
        end
    endtask

    initial begin
        sb                = new();
        clock_ms          = TIME_MAX - 32'($urandom_range(2_000_000));
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_bssid           <= '0;
        i_packet_count    <= '0;
        i_tx_byte_count   <= '0;
        i_rx_byte_count   <= '0;
        i_byte_sum        <= '0;
        i_byte_square_sum <= '0;
        i_seen_time_ms    <= '0;
        i_signal_dbm      <= '0;
        i_signal_low_dbm  <= '0;
        i_signal_high_dbm <= '0;
        i_now_ms          <= '0;
        i_last_in_batch   <= 1'b0;
        i_out_stall       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, counter wrap and the unset rules for low and high.
        push_record(fixed_record('0, '0, '0, '0, 8'h80, 8'h00, 8'h00, '0, 1'b0));
        push_record(fixed_record('1, '1, '1, '1, 8'h7F, 8'h80, 8'h7F, '1, 1'b1));
        // Stored low and high are unset, so a zero low and a high of -5 win.
        push_record(fixed_record('0, '1, '1, 32'd5, 8'h00, 8'h00, 8'hFB, 32'd10, 1'b0));
        // Low still unset takes -10; a record high of 0 beats -5 as a plain value.
        push_record(fixed_record('0, 32'd1, 64'd1, 32'd6, 8'd20, 8'hF6, 8'h00, 32'd11,
                                 1'b1));
        // High is zero again, hence unset, and -100 overwrites it.
        push_record(fixed_record('0, 32'd1, 64'd1, 32'd7, 8'hFF, 8'd3, 8'h9C, 32'd12,
                                 1'b0));
        push_record(fixed_record('1, '0, '0, '0, 8'h80, 8'h7F, 8'h80, '0, 1'b1));
        push_record(fixed_record(48'h5555_5555_5555, 32'h5555_5555, {2{32'h5555_5555}},
                                 32'h5555_5555, 8'h55, 8'hAA, 8'h55, 32'h5555_5555, 1'b1));
        push_record(fixed_record(48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, {2{32'hAAAA_AAAA}},
                                 32'hAAAA_AAAA, 8'hAA, 8'h55, 8'hAA, 32'hAAAA_AAAA, 1'b0));
        push_record(fixed_record(48'h8000_0000_0001, 32'h8000_0001, 64'h8000_0000_0000_0001,
                                 32'h8000_0000, 8'h01, 8'h81, 8'h7E, 32'h0000_0001, 1'b1));

        run_segment(22'd0, 6, 75, 1'b0, 250);
        run_segment(22'd3_600_000, 6, 75, 1'b1, 250);
        run_segment(22'($urandom_range(200_000, 1000)), 75, 6, 1'b0, 250);
        run_segment(STALE_AGE_RST, 75, 6, 1'b0, 250);
        run_segment(22'($urandom_range(200_000, 1000)), 0, 0, 1'b0, 300);
        run_segment(22'd3_600_000, 0, 0, 1'b1, 150);
        run_segment(22'($urandom_range(20_000, 1)), 0, 0, 1'b0, 190);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
